// File: design/delta_reorder_jitter_buffer_unit_defines.svh
// Assertion macros for the delta reorder jitter buffer.
// Included by the top level; no other dependencies.
`ifndef DELTA_REORDER_JITTER_BUFFER_UNIT_DEFINES_SVH
`define DELTA_REORDER_JITTER_BUFFER_UNIT_DEFINES_SVH
`ifndef SYNTHESIS
`define DRJB_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define DRJB_ASSERT_NORST(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define DRJB_ASSERT(label, clk, rst_n, prop, msg)
`define DRJB_ASSERT_NORST(label, clk, prop, msg)
`endif
`endif

// File: design/drjb_pkg.sv
// Shared types and constants for the delta reorder jitter buffer.
// No dependencies.
`default_nettype none
package drjb_pkg;
    localparam int SLOTS_DEF       = 8;
    localparam int TICK_BITS_DEF   = 32;
    localparam int HANDLE_BITS_DEF = 8;

    localparam logic [1:0] CMD_FULL  = 2'd0;
    localparam logic [1:0] CMD_DELTA = 2'd1;
    localparam logic [1:0] CMD_TICK  = 2'd2;

    localparam logic [2:0] OC_OK     = 3'd0;
    localparam logic [2:0] OC_CRC    = 3'd1;
    localparam logic [2:0] OC_DUP    = 3'd2;
    localparam logic [2:0] OC_OLD    = 3'd3;
    localparam logic [2:0] OC_BUF    = 3'd4;
    localparam logic [2:0] OC_TICK   = 3'd5;

    localparam logic [1:0] CFG_SLOTS   = 2'd0;
    localparam logic [1:0] CFG_MAXAGE  = 2'd1;
    localparam logic [1:0] CFG_AUTOREQ = 2'd2;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DECIDE,
        ST_INSERT,
        ST_PROMOTE,
        ST_EVICT,
        ST_FINAL
    } eng_state_t;
endpackage
`default_nettype wire

// File: design/drjb_front.sv
// Front end: accept input items into a two-entry command queue.
// Depends on drjb_pkg.
`default_nettype none
module drjb_front #(
    parameter int TICK_BITS   = drjb_pkg::TICK_BITS_DEF,
    parameter int HANDLE_BITS = drjb_pkg::HANDLE_BITS_DEF,
    localparam int W = 2 + 2 * TICK_BITS + HANDLE_BITS + 1
) (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         in_valid,
    output logic              in_ready,
    input  wire logic [W-1:0] in_word,
    output logic              q_valid,
    input  wire logic         q_pop,
    output logic [W-1:0]      q_word
);
    import drjb_pkg::*;

    logic [W-1:0] mem_reg [2];
    logic         wp_reg, wp_next, rp_reg, rp_next;
    logic [1:0]   cnt_reg, cnt_next;
    logic         push;

    assign in_ready = (cnt_reg != 2'd2);
    assign push     = in_valid && in_ready;
    assign q_valid  = (cnt_reg != 2'd0);
    assign q_word   = mem_reg[rp_reg];

    always_comb
    begin
        wp_next  = push ? ~wp_reg : wp_reg;
        rp_next  = q_pop ? ~rp_reg : rp_reg;
        cnt_next = cnt_reg + {1'b0, push} - {1'b0, q_pop};
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wp_reg] <= in_word;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            wp_reg  <= wp_next;
            rp_reg  <= rp_next;
            cnt_reg <= cnt_next;
        end
    end
endmodule
`default_nettype wire

// File: design/drjb_engine.sv
// Back end: sorted jitter buffer and the command sequencer, one entry per step.
// Depends on drjb_pkg.
`default_nettype none
module drjb_engine #(
    parameter int SLOTS       = drjb_pkg::SLOTS_DEF,
    parameter int TICK_BITS   = drjb_pkg::TICK_BITS_DEF,
    parameter int HANDLE_BITS = drjb_pkg::HANDLE_BITS_DEF,
    localparam int W  = 2 + 2 * TICK_BITS + HANDLE_BITS + 1,
    localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1,
    localparam int CW = $clog2(SLOTS + 1)
) (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         q_valid,
    output logic              q_pop,
    input  wire logic [W-1:0] q_word,
    input  wire logic [3:0]   cfg_slots,
    input  wire logic [31:0]  cfg_max_age,
    input  wire logic         cfg_auto_req,
    output logic              r_valid,
    input  wire logic         r_ready,
    output logic              r_kind,
    output logic [7:0]        r_handle,
    output logic [31:0]       r_tick,
    output logic [2:0]        r_outcome,
    output logic              r_req,
    output logic              r_evict,
    output logic              r_last,
    output logic [CW-1:0]     count
);
    import drjb_pkg::*;

    localparam int TB = TICK_BITS;
    localparam int HB = HANDLE_BITS;

    logic [TB-1:0] eb_reg [SLOTS];
    logic [TB-1:0] es_reg [SLOTS];
    logic [HB-1:0] eh_reg [SLOTS];

    eng_state_t    st_reg, st_next;
    logic [TB-1:0] la_reg;
    logic [CW-1:0] cnt_reg;
    logic [CW-1:0] rd_reg, wr_reg;
    logic [1:0]    cmd_reg;
    logic [TB-1:0] srv_reg, base_reg;
    logic [HB-1:0] h_reg;
    logic          crc_reg;
    logic [2:0]    oc_reg;
    logic          evf_reg, any_reg, req_reg;

    // most recent apply, held back until it is known whether it is the last result
    logic [HB-1:0] ph_reg;
    logic [TB-1:0] pt_reg;

    // output register (one result pending)
    logic          ov_reg;
    logic          ok_reg, ol_reg, orq_reg, oev_reg;
    logic [7:0]    oh_reg;
    logic [31:0]   ot_reg;
    logic [2:0]    oo_reg;

    logic          slot_free;
    logic [CW-1:0] cap;
    logic [IW-1:0] ri, wi;
    logic [TB-1:0] lead;
    logic          stale;
    logic          dec_apply;
    logic          emit;
    logic          emit_kind, emit_last, emit_req, emit_ev;
    logic [2:0]    emit_oc;
    logic [HB-1:0] emit_h;
    logic [TB-1:0] emit_tick;

    assign slot_free = !ov_reg || r_ready;
    assign ri = rd_reg[IW-1:0];
    assign wi = wr_reg[IW-1:0];
    assign count = cnt_reg;

    always_comb
    begin
        if (cfg_slots == 4'd0)
            cap = CW'(1);
        else if ({28'd0, cfg_slots} > 32'(SLOTS))
            cap = CW'(SLOTS);
        else
            cap = CW'(cfg_slots);
    end

    assign lead  = (es_reg[ri] > la_reg) ? es_reg[ri] - la_reg : '0;
    assign stale = (cfg_max_age != 32'd0) && (la_reg != '0)
                   && ({{(64-TB){1'b0}}, lead} > {32'd0, cfg_max_age});

    // set when the incoming snapshot is applied at once
    assign dec_apply = (cmd_reg == CMD_FULL && !crc_reg && srv_reg > la_reg)
                       || (cmd_reg == CMD_DELTA && base_reg == la_reg)
                       || (cmd_reg == CMD_DELTA && base_reg > la_reg && base_reg == srv_reg);

    assign q_pop = (st_reg == ST_IDLE) && q_valid;

    // next state
    always_comb
    begin
        st_next = st_reg;
        case (st_reg)
            ST_IDLE:    if (q_valid) st_next = ST_DECIDE;
            ST_DECIDE:
            begin
                if (slot_free)
                begin
                    st_next = ST_FINAL;
                    if (cmd_reg == CMD_TICK)
                        st_next = ST_PROMOTE;
                    else if (cmd_reg == CMD_DELTA && base_reg == la_reg)
                        st_next = ST_PROMOTE;
                    else if (cmd_reg == CMD_DELTA && base_reg > la_reg
                             && base_reg != srv_reg)
                        st_next = ST_INSERT;
                end
            end
            ST_INSERT:  if (rd_reg == '0 || wr_reg != '0) st_next = ST_FINAL;
            ST_PROMOTE:
            begin
                if (rd_reg >= cnt_reg && slot_free)
                    st_next = (cmd_reg == CMD_TICK) ? ST_EVICT : ST_FINAL;
            end
            ST_EVICT:   if (rd_reg >= cnt_reg) st_next = ST_FINAL;
            ST_FINAL:   if (slot_free) st_next = ST_IDLE;
            default:    st_next = ST_IDLE;
        endcase
    end

    // result outputs
    always_comb
    begin
        emit      = 1'b0;
        emit_kind = 1'b0;
        emit_h    = h_reg;
        emit_tick = la_reg;
        emit_last = 1'b0;
        emit_oc   = OC_OK;
        emit_req  = 1'b0;
        emit_ev   = 1'b0;
        case (st_reg)
            ST_PROMOTE:
            begin
                // a new apply pushes out the one held back before it
                if (rd_reg < cnt_reg && eb_reg[ri] == la_reg && any_reg)
                begin
                    emit = 1'b1; emit_h = ph_reg; emit_tick = pt_reg;
                end
            end
            ST_FINAL:
            begin
                emit      = 1'b1;
                emit_last = 1'b1;
                emit_oc   = oc_reg;
                emit_req  = req_reg;
                emit_ev   = evf_reg;
                if (any_reg)
                begin
                    emit_h    = ph_reg;
                    emit_tick = pt_reg;
                end
                else
                begin
                    emit_kind = 1'b1;
                    emit_h    = '0;
                end
            end
            default: emit = 1'b0;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            {crc_reg, h_reg, base_reg, srv_reg, cmd_reg} <= q_word;
        end
        if (st_reg == ST_DECIDE)
        begin
            ph_reg <= h_reg;
            pt_reg <= srv_reg;
        end
        if (st_reg == ST_PROMOTE && slot_free && rd_reg < cnt_reg && eb_reg[ri] == la_reg)
        begin
            ph_reg <= eh_reg[ri];
            pt_reg <= es_reg[ri];
        end
        if (st_reg == ST_INSERT && rd_reg != '0 && wr_reg == '0)
        begin
            // shift one entry up; drop the new item in place when the slot below is smaller
            if (rd_reg == CW'(1) || eb_reg[IW'(rd_reg - CW'(2))] < base_reg)
            begin
                eb_reg[IW'(rd_reg - CW'(1))] <= base_reg;
                es_reg[IW'(rd_reg - CW'(1))] <= srv_reg;
                eh_reg[IW'(rd_reg - CW'(1))] <= h_reg;
            end
            else
            begin
                eb_reg[IW'(rd_reg - CW'(1))] <= eb_reg[IW'(rd_reg - CW'(2))];
                es_reg[IW'(rd_reg - CW'(1))] <= es_reg[IW'(rd_reg - CW'(2))];
                eh_reg[IW'(rd_reg - CW'(1))] <= eh_reg[IW'(rd_reg - CW'(2))];
            end
        end
        if (st_reg == ST_DECIDE && slot_free && cmd_reg == CMD_DELTA
            && base_reg > la_reg && base_reg != srv_reg && cnt_reg >= cap
            && cnt_reg != '0)
        begin
            // evict the oldest: shift everything down by one
            for (int k = 0; k + 1 < SLOTS; k++)
            begin
                eb_reg[k] <= eb_reg[k+1];
                es_reg[k] <= es_reg[k+1];
                eh_reg[k] <= eh_reg[k+1];
            end
        end
        if ((st_reg == ST_PROMOTE && slot_free && rd_reg < cnt_reg && eb_reg[ri] != la_reg)
            || (st_reg == ST_EVICT && rd_reg < cnt_reg && !stale))
        begin
            eb_reg[wi] <= eb_reg[ri];
            es_reg[wi] <= es_reg[ri];
            eh_reg[wi] <= eh_reg[ri];
        end
        if (emit && slot_free)
        begin
            ok_reg  <= emit_kind;
            oh_reg  <= 8'(emit_h);
            ot_reg  <= 32'(emit_tick);
            oo_reg  <= emit_oc;
            orq_reg <= emit_req;
            oev_reg <= emit_ev;
            ol_reg  <= emit_last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg  <= ST_IDLE;
            la_reg  <= '0;
            cnt_reg <= '0;
            rd_reg  <= '0;
            wr_reg  <= '0;
            oc_reg  <= OC_OK;
            evf_reg <= 1'b0;
            any_reg <= 1'b0;
            req_reg <= 1'b0;
            ov_reg  <= 1'b0;
        end
        else
        begin
            st_reg <= st_next;
            if (emit && slot_free)
                ov_reg <= 1'b1;
            else if (r_ready)
                ov_reg <= 1'b0;
            case (st_reg)
                ST_IDLE:
                begin
                    evf_reg <= 1'b0;
                    any_reg <= 1'b0;
                    req_reg <= 1'b0;
                    oc_reg  <= OC_OK;
                    rd_reg  <= '0;
                    wr_reg  <= '0;
                end
                ST_DECIDE:
                begin
                    if (slot_free)
                    begin
                        any_reg <= dec_apply;
                        case (cmd_reg)
                            CMD_FULL:
                            begin
                                if (crc_reg)                oc_reg <= OC_CRC;
                                else if (srv_reg == la_reg) oc_reg <= OC_DUP;
                                else if (srv_reg < la_reg)  oc_reg <= OC_OLD;
                                else
                                begin
                                    la_reg  <= srv_reg;
                                    cnt_reg <= '0;
                                end
                            end
                            CMD_DELTA:
                            begin
                                if (base_reg == la_reg)
                                    la_reg <= srv_reg;
                                else if (base_reg < la_reg)
                                    oc_reg <= OC_OLD;
                                else if (base_reg == srv_reg)
                                    la_reg <= srv_reg;
                                else
                                begin
                                    oc_reg <= OC_BUF;
                                    if (cnt_reg >= cap && cnt_reg != '0)
                                    begin
                                        evf_reg <= 1'b1;
                                        rd_reg  <= cnt_reg;
                                        cnt_reg <= cnt_reg;
                                    end
                                    else
                                    begin
                                        rd_reg  <= cnt_reg + CW'(1);
                                        cnt_reg <= cnt_reg + CW'(1);
                                    end
                                end
                            end
                            CMD_TICK: oc_reg <= OC_TICK;
                            default:  oc_reg <= OC_OK;
                        endcase
                    end
                end
                ST_INSERT:
                begin
                    // walk down from the top; wr flags placement done
                    if (rd_reg != '0 && wr_reg == '0)
                    begin
                        if (rd_reg == CW'(1) || eb_reg[IW'(rd_reg - CW'(2))] < base_reg)
                            wr_reg <= CW'(1);
                        rd_reg <= rd_reg - CW'(1);
                    end
                end
                ST_PROMOTE:
                begin
                    if (slot_free)
                    begin
                        if (rd_reg < cnt_reg)
                        begin
                            rd_reg <= rd_reg + CW'(1);
                            if (eb_reg[ri] == la_reg)
                            begin
                                la_reg  <= es_reg[ri];
                                any_reg <= 1'b1;
                            end
                            else
                                wr_reg <= wr_reg + CW'(1);
                        end
                        else
                        begin
                            // request flag reflects the buffer right after the pass
                            req_reg <= cfg_auto_req && wr_reg != '0 && eb_reg[0] < la_reg;
                            cnt_reg <= wr_reg;
                            rd_reg  <= '0;
                            wr_reg  <= '0;
                        end
                    end
                end
                ST_EVICT:
                begin
                    if (rd_reg < cnt_reg)
                    begin
                        rd_reg <= rd_reg + CW'(1);
                        if (!stale) wr_reg <= wr_reg + CW'(1);
                    end
                    else
                        cnt_reg <= wr_reg;
                end
                default: ;
            endcase
        end
    end

    assign r_valid   = ov_reg;
    assign r_kind    = ok_reg;
    assign r_handle  = oh_reg;
    assign r_tick    = ot_reg;
    assign r_outcome = oo_reg;
    assign r_req     = orq_reg;
    assign r_evict   = oev_reg;
    assign r_last    = ol_reg;
endmodule
`default_nettype wire

// File: design/delta_reorder_jitter_buffer_unit.sv
// Top level of the delta reorder jitter buffer: config registers, front queue, engine.
// Depends on drjb_pkg, drjb_front, drjb_engine and the defines header.
//
// channel   dir  handshake                fields
// s_axis    in   s_axis_tvalid/tready     tdata: command, server_tick, baseline_tick,
//                                          handle, crc_bad
// m_axis    out  m_axis_tvalid/tready     tdata: result_kind, apply_handle, applied_tick,
//                                          outcome, request_full, overflow_evict; tlast
// cfg       in   cfg_valid/cfg_ready      cfg_index, cfg_data
//
// An item goes through fetch and decide, then one buffer entry per step plus a closing step
// in the insert shift, promotion pass and stale sweep of the engine, then the final result.
// A two-entry queue takes items while the engine works; one output register holds
// each result, and a stalled output holds the engine. Reset clears all control state.
`default_nettype none
`include "delta_reorder_jitter_buffer_unit_defines.svh"
module delta_reorder_jitter_buffer_unit #(
    parameter int SLOTS       = drjb_pkg::SLOTS_DEF,
    parameter int TICK_BITS   = drjb_pkg::TICK_BITS_DEF,
    parameter int HANDLE_BITS = drjb_pkg::HANDLE_BITS_DEF,
    localparam int IW = 2 + 2 * TICK_BITS + HANDLE_BITS + 1,
    localparam int IB = ((IW + 7) / 8) * 8
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          s_axis_tvalid,
    output logic               s_axis_tready,
    // command, server_tick, baseline_tick, handle, crc_bad (low bit up)
    input  wire logic [IB-1:0] s_axis_tdata,
    output logic               m_axis_tvalid,
    input  wire logic          m_axis_tready,
    // result_kind, apply_handle, applied_tick, outcome, request_full, overflow_evict
    output logic [47:0]        m_axis_tdata,
    output logic               m_axis_tlast,
    input  wire logic          cfg_valid,
    output logic               cfg_ready,
    input  wire logic [1:0]    cfg_index,
    input  wire logic [31:0]   cfg_data
);
    import drjb_pkg::*;

    localparam int CW = $clog2(SLOTS + 1);

    logic [3:0]  slots_reg;
    logic [31:0] max_age_reg;
    logic        auto_req_reg;

    logic          q_valid, q_pop;
    logic [IW-1:0] q_word;
    logic          r_kind, r_req, r_evict;
    logic [7:0]    r_handle;
    logic [31:0]   r_tick;
    logic [2:0]    r_outcome;
    logic [CW-1:0] count;

    assign cfg_ready = 1'b1;

    // hold config; writes must arrive only while idle, which the block itself does not enforce
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slots_reg    <= 4'd8;
            max_age_reg  <= 32'd0;
            auto_req_reg <= 1'b0;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                CFG_SLOTS:   slots_reg    <= cfg_data[3:0];
                CFG_MAXAGE:  max_age_reg  <= cfg_data;
                CFG_AUTOREQ: auto_req_reg <= cfg_data[0];
                default:     ;
            endcase
        end
    end

    drjb_front #(.TICK_BITS(TICK_BITS), .HANDLE_BITS(HANDLE_BITS)) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .in_word  (s_axis_tdata[IW-1:0]),
        .q_valid  (q_valid),
        .q_pop    (q_pop),
        .q_word   (q_word)
    );

    drjb_engine #(.SLOTS(SLOTS), .TICK_BITS(TICK_BITS), .HANDLE_BITS(HANDLE_BITS)) u_eng (
        .clk          (clk),
        .rst_n        (rst_n),
        .q_valid      (q_valid),
        .q_pop        (q_pop),
        .q_word       (q_word),
        .cfg_slots    (slots_reg),
        .cfg_max_age  (max_age_reg),
        .cfg_auto_req (auto_req_reg),
        .r_valid      (m_axis_tvalid),
        .r_ready      (m_axis_tready),
        .r_kind       (r_kind),
        .r_handle     (r_handle),
        .r_tick       (r_tick),
        .r_outcome    (r_outcome),
        .r_req        (r_req),
        .r_evict      (r_evict),
        .r_last       (m_axis_tlast),
        .count        (count)
    );

    assign m_axis_tdata = {2'b00, r_evict, r_req, r_outcome, r_tick, r_handle, r_kind};

    `DRJB_ASSERT(a_count_range, clk, rst_n, count <= CW'(SLOTS), "buffer count exceeds slots")
    `DRJB_ASSERT(a_kind_last, clk, rst_n, (m_axis_tvalid && r_kind) |-> m_axis_tlast, "outcome item not last")
    `DRJB_ASSERT(a_flags_last, clk, rst_n, (m_axis_tvalid && (r_req || r_evict)) |-> m_axis_tlast, "flags on non-last item")
endmodule
`default_nettype wire

// File: tb/sv/tb_delta_reorder_jitter_buffer_unit.sv
// Testbench for the delta reorder jitter buffer: directed and random snapshot traffic
// checked item by item against an in-bench model of the buffer.
// Depends on drjb_pkg and delta_reorder_jitter_buffer_unit.
`default_nettype none
module tb_delta_reorder_jitter_buffer_unit;
    timeunit 1ns;
    timeprecision 1ps;
    import drjb_pkg::*;

    localparam int NSLOT = 8;
    localparam int DRAIN_CYCLES = 60;
    localparam longint CYCLE_LIMIT = 400000;
    // command code with no meaning; the block must leave its state alone
    localparam logic [1:0] CMD_NONE = 2'd3;

    // one result item as the block reports it
    typedef struct packed {
        logic        kind;
        logic [7:0]  hnd;
        logic [31:0] tick;
        logic [2:0]  oc;
        logic        req;
        logic        evict;
        logic        lst;
    } result_t;

    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    // command, server_tick, baseline_tick, handle, crc_bad (low bit up)
    logic [79:0] s_axis_tdata;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    // result_kind, apply_handle, applied_tick, outcome, request_full, overflow_evict
    logic [47:0] m_axis_tdata;
    logic        m_axis_tlast;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [1:0]  cfg_index;
    logic [31:0] cfg_data;

    delta_reorder_jitter_buffer_unit i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    // shadow copy of the buffer state and registers
    logic [3:0]  slots_reg;
    logic [31:0] age_reg;
    logic        autoreq_reg;
    logic [31:0] applied;
    logic [31:0] buf_base [NSLOT];
    logic [31:0] buf_srv [NSLOT];
    logic [7:0]  buf_hnd [NSLOT];
    int          buf_count;

    result_t     expected_results[$];
    int          send_idle_pct;
    int          recv_idle_pct;
    int          hold_off_cycles;
    bit          failed;
    longint      cycles;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // hard stop if the block hangs
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("TEST FAILED");
            $finish;
        end
    end

    function automatic result_t make_result(logic kind, logic [7:0] h);
        result_t r;
        r = '0;
        r.kind = kind;
        r.hnd = h;
        r.tick = applied;
        return r;
    endfunction

    function automatic void drop_entry(int idx);
        for (int k = idx; k + 1 < buf_count; k++)
        begin
            buf_base[k] = buf_base[k+1];
            buf_srv[k] = buf_srv[k+1];
            buf_hnd[k] = buf_hnd[k+1];
        end
        buf_count--;
    endfunction

    // promote every entry whose baseline matches, in buffer order; returns request flag
    function automatic logic promote_pass(ref result_t res[$]);
        int wr;
        wr = 0;
        for (int rd = 0; rd < buf_count; rd++)
        begin
            if (buf_base[rd] == applied)
            begin
                applied = buf_srv[rd];
                res.push_back(make_result(1'b0, buf_hnd[rd]));
            end
            else
            begin
                buf_base[wr] = buf_base[rd];
                buf_srv[wr] = buf_srv[rd];
                buf_hnd[wr] = buf_hnd[rd];
                wr++;
            end
        end
        buf_count = wr;
        return buf_count > 0 && autoreq_reg && buf_base[0] < applied;
    endfunction

    // work out the result items of one input item and advance the shadow state
    function automatic void predict_buffer(logic [1:0] cmd, logic [31:0] srv,
                                           logic [31:0] base, logic [7:0] h, logic crc);
        result_t res[$];
        logic [2:0] oc;
        logic req;
        logic ev;
        int cap;
        int pos;
        result_t r;
        oc = OC_OK;
        req = 1'b0;
        ev = 1'b0;
        if (cmd == CMD_FULL)
        begin
            if (crc) oc = OC_CRC;
            else if (srv == applied) oc = OC_DUP;
            else if (srv < applied) oc = OC_OLD;
            else
            begin
                applied = srv;
                buf_count = 0;
                res.push_back(make_result(1'b0, h));
            end
        end
        else if (cmd == CMD_DELTA)
        begin
            if (base == applied)
            begin
                applied = srv;
                res.push_back(make_result(1'b0, h));
                req = promote_pass(res);
            end
            else if (base < applied) oc = OC_OLD;
            else if (base == srv)
            begin
                applied = srv;
                res.push_back(make_result(1'b0, h));
            end
            else
            begin
                cap = (slots_reg == 0) ? 1 : (slots_reg > NSLOT ? NSLOT : slots_reg);
                if (buf_count >= cap && buf_count > 0)
                begin
                    drop_entry(0);
                    ev = 1'b1;
                end
                pos = 0;
                while (pos < buf_count && buf_base[pos] < base) pos++;
                for (int k = buf_count; k > pos; k--)
                begin
                    buf_base[k] = buf_base[k-1];
                    buf_srv[k] = buf_srv[k-1];
                    buf_hnd[k] = buf_hnd[k-1];
                end
                buf_base[pos] = base;
                buf_srv[pos] = srv;
                buf_hnd[pos] = h;
                buf_count++;
                oc = OC_BUF;
            end
        end
        else if (cmd == CMD_TICK)
        begin
            req = promote_pass(res);
            // drop entries that lead too far; nothing goes while the tick is invalid
            if (age_reg != 0 && applied != 0)
            begin
                pos = 0;
                while (pos < buf_count)
                begin
                    if (buf_srv[pos] > applied && buf_srv[pos] - applied > age_reg)
                        drop_entry(pos);
                    else
                        pos++;
                end
            end
            oc = OC_TICK;
        end
        if (res.size() == 0) res.push_back(make_result(1'b1, 8'd0));
        r = res.pop_back();
        r.oc = oc;
        r.req = req;
        r.evict = ev;
        r.lst = 1'b1;
        res.push_back(r);
        foreach (res[i]) expected_results.push_back(res[i]);
    endfunction

    // check each result item against the oldest expectation
    always @(posedge clk)
    begin
        result_t got;
        result_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got = {m_axis_tdata[0], m_axis_tdata[8:1], m_axis_tdata[40:9],
                   m_axis_tdata[43:41], m_axis_tdata[44], m_axis_tdata[45], m_axis_tlast};
            if (expected_results.size() == 0)
            begin
                $display("%0t: unexpected result item %h", $time, got);
                failed = 1'b1;
            end
            else
            begin
                want = expected_results.pop_front();
                if (got.kind !== want.kind || got.hnd !== want.hnd || got.tick !== want.tick
                    || got.oc !== want.oc || got.req !== want.req
                    || got.evict !== want.evict || got.lst !== want.lst)
                begin
                    $display({"%0t: mismatch expected kind=%0d hnd=%0d tick=%0d oc=%0d",
                              " req=%0d ev=%0d last=%0d"},
                             $time, want.kind, want.hnd, want.tick, want.oc, want.req,
                             want.evict, want.lst);
                    $display({"%0t:          actual kind=%0d hnd=%0d tick=%0d oc=%0d",
                              " req=%0d ev=%0d last=%0d"},
                             $time, got.kind, got.hnd, got.tick, got.oc, got.req,
                             got.evict, got.lst);
                    failed = 1'b1;
                end
            end
        end
    end

    // receiver: random stalls, or a long hold-off when asked
    always @(posedge clk)
    begin
        if (hold_off_cycles > 0)
        begin
            hold_off_cycles <= hold_off_cycles - 1;
            m_axis_tready <= 1'b0;
        end
        else
            m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // offer one item, with random idle cycles in front; hold until accepted
    task automatic send_item(logic [1:0] cmd, logic [31:0] srv, logic [31:0] base,
                             logic [7:0] h, logic crc);
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {5'd0, crc, h, base, srv, cmd};
        do @(posedge clk); while (!s_axis_tready);
        predict_buffer(cmd, srv, base, h, crc);
    endtask

    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        while (expected_results.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [31:0] val);
        wait_drained();
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        if (idx == CFG_SLOTS) slots_reg = val[3:0];
        else if (idx == CFG_MAXAGE) age_reg = val;
        else autoreq_reg = val[0];
    endtask

    // full snapshots: crc, duplicate, old, extremes, and an unused command code
    task automatic test_full_snapshots();
        send_item(CMD_FULL, 32'd100, 32'hFFFF_FFFF, 8'hFF, 1'b1);
        send_item(CMD_FULL, 32'd100, 32'd0, 8'h01, 1'b0);
        send_item(CMD_FULL, 32'd100, 32'd0, 8'h02, 1'b0);
        send_item(CMD_FULL, 32'd50, 32'd0, 8'h03, 1'b0);
        send_item(CMD_FULL, 32'hFFFF_FFFE, 32'd0, 8'hFF, 1'b0);
        send_item(CMD_FULL, 32'hFFFF_FFFF, 32'd0, 8'h00, 1'b0);
        send_item(CMD_NONE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 8'hFF, 1'b1);
    endtask

    // deltas: match, old baseline, self baseline, insert order, overflow, promotion
    task automatic test_delta_ordering();
        write_reg(CFG_SLOTS, 32'd0);
        write_reg(CFG_AUTOREQ, 32'd1);
        send_item(CMD_FULL, 32'd10, 32'd0, 8'd1, 1'b0);
        send_item(CMD_DELTA, 32'd12, 32'd10, 8'd2, 1'b0);
        send_item(CMD_DELTA, 32'd13, 32'd5, 8'd3, 1'b0);
        send_item(CMD_DELTA, 32'd20, 32'd20, 8'd4, 1'b0);
        send_item(CMD_DELTA, 32'd25, 32'd22, 8'd5, 1'b0);
        send_item(CMD_DELTA, 32'd27, 32'd25, 8'd6, 1'b0);
        write_reg(CFG_SLOTS, 32'd15);
        send_item(CMD_DELTA, 32'd24, 32'd22, 8'd7, 1'b0);
        send_item(CMD_DELTA, 32'd22, 32'd21, 8'd8, 1'b0);
        send_item(CMD_DELTA, 32'd30, 32'd27, 8'd9, 1'b0);
        send_item(CMD_DELTA, 32'd21, 32'd20, 8'd10, 1'b0);
        send_item(CMD_TICK, 32'd0, 32'd0, 8'd0, 1'b0);
    endtask

    // ticks: stale eviction and the full request flag
    task automatic test_tick_eviction();
        write_reg(CFG_MAXAGE, 32'd5);
        send_item(CMD_TICK, 32'd0, 32'd0, 8'd0, 1'b0);
        send_item(CMD_DELTA, 32'd80, 32'd60, 8'd11, 1'b0);
        send_item(CMD_DELTA, 32'd34, 32'd31, 8'd12, 1'b0);
        send_item(CMD_TICK, 32'd0, 32'd0, 8'd0, 1'b0);
        write_reg(CFG_MAXAGE, 32'hFFFF_FFFF);
        send_item(CMD_TICK, 32'd0, 32'd0, 8'd0, 1'b0);
    endtask

    // random streams: mostly deltas near the applied tick, some noise
    task automatic test_random_stream(int count);
        logic [31:0] base;
        logic [31:0] srv;
        int pick;
        for (int i = 0; i < count; i++)
        begin
            pick = $urandom_range(99);
            base = applied + $urandom_range(6);
            srv = base + $urandom_range(4);
            if (pick < 6)
                send_item(CMD_FULL, applied + $urandom_range(3) - 1, $urandom, 8'($urandom),
                          ($urandom_range(3) == 0));
            else if (pick < 70)
                send_item(CMD_DELTA, srv, base, 8'($urandom), 1'($urandom));
            else if (pick < 86)
                send_item(CMD_TICK, $urandom, $urandom, 8'($urandom), 1'($urandom));
            else if (pick < 93)
                send_item(CMD_DELTA, $urandom, $urandom, 8'($urandom), 1'($urandom));
            else
                send_item(2'($urandom_range(3)), $urandom, $urandom, 8'($urandom),
                          1'($urandom));
        end
    endtask

    // block the output long enough for the front queue to fill and stall input
    task automatic test_backpressure();
        hold_off_cycles = 200;
        test_random_stream(20);
    endtask

    initial
    begin
        rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        m_axis_tready = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = CFG_SLOTS;
        cfg_data = '0;
        slots_reg = 4'd8;
        age_reg = '0;
        autoreq_reg = 1'b0;
        applied = '0;
        buf_count = 0;
        hold_off_cycles = 0;
        failed = 1'b0;
        cycles = 0;
        send_idle_pct = 35;
        recv_idle_pct = 74;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_full_snapshots();
        test_delta_ordering();
        test_tick_eviction();

        write_reg(CFG_SLOTS, 32'd3);
        write_reg(CFG_MAXAGE, 32'd8);
        write_reg(CFG_AUTOREQ, 32'd0);
        test_random_stream(120);
        send_idle_pct = 74;
        recv_idle_pct = 35;
        write_reg(CFG_SLOTS, 32'd1);
        write_reg(CFG_MAXAGE, 32'd0);
        write_reg(CFG_AUTOREQ, 32'd1);
        test_random_stream(110);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        write_reg(CFG_SLOTS, 32'd8);
        write_reg(CFG_MAXAGE, 32'd3);
        test_backpressure();
        test_random_stream(110);

        wait_drained();
        if (!failed)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end
endmodule
`default_nettype wire
